// ===== hw/rtl/sce_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sce_pkg;

   localparam int PIX_W   = 16;
   localparam int TAP_W   = 18;
   localparam int VAL_W   = 24;
   localparam int OPA_W   = 25;
   localparam int PROD_W  = OPA_W + TAP_W;
   localparam int ACC_W   = 50;

   localparam logic [1:0] MODE_PIXEL = 2'd0;
   localparam logic [1:0] MODE_HTAP  = 2'd1;
   localparam logic [1:0] MODE_VTAP  = 2'd2;

   localparam logic [1:0] REG_ROW_LENGTH = 2'd0;
   localparam logic [1:0] REG_ROW_COUNT  = 2'd1;
   localparam logic [1:0] REG_HWIDTH     = 2'd2;
   localparam logic [1:0] REG_VWIDTH     = 2'd3;

   typedef struct packed {
      logic clear;
      logic valid;
   } mac_ctl_type;

   function automatic logic signed [VAL_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
      logic             neg;
      logic [ACC_W-1:0] mag;
      logic [ACC_W-1:0] q;
      logic signed [VAL_W-1:0] ret;
      neg = acc[ACC_W-1];
      mag = neg ? (~acc + 1'b1) : acc;
      q   = (mag + ACC_W'(32768)) >> 16;
      if (neg) begin
         if (q > ACC_W'(8388608)) ret = 24'sh800000;
         else ret = VAL_W'(~q + 1'b1);
      end else begin
         if (q > ACC_W'(8388607)) ret = 24'sh7FFFFF;
         else ret = VAL_W'(q);
      end
      return ret;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/sce_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sce_cell (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        shift_en,
   input  wire logic        rot_en,
   input  wire logic [15:0] shift_in,
   input  wire logic [15:0] rot_in,
   output logic      [15:0] q
);
   import sce_pkg::*;

   logic [PIX_W-1:0] q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff <= '0;
      end else if (shift_en) begin
         q_ff <= shift_in;
      end else if (rot_en) begin
         q_ff <= rot_in;
      end
   end

   assign q = q_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/sce_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sce_mac (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire sce_pkg::mac_ctl_type                ctl,
   input  wire logic signed [sce_pkg::OPA_W-1:0]    a,
   input  wire logic signed [sce_pkg::TAP_W-1:0]    b,
   output logic signed      [sce_pkg::ACC_W-1:0]    acc
);
   import sce_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic                     pv_ff;
   logic signed [ACC_W-1:0]  acc_ff;

   always_ff @(posedge clock) begin
      prod_ff <= a * b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff  <= 1'b0;
         acc_ff <= '0;
      end else if (ctl.clear) begin
         pv_ff  <= 1'b0;
         acc_ff <= '0;
      end else begin
         pv_ff <= ctl.valid;
         if (pv_ff) acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
   end

   assign acc = acc_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/separable_convolution_zero_border.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A tap load or ignored word is taken and done in ST_IDLE; a pixel is done there too when it
// is inside the leading horizontal border, else it passes on through ST_HMAC, ST_HWR, ST_VMAC
// and ST_OUT as needed (window rotation through the shared multiply-accumulate, then one row_store read
// per vertical tap). One word is in work at a time; a finished result waits in the output
// register while the next word is taken. Synchronous reset starts a clearing pass over all
// MAX_TAPS * 2**clog2(MAX_COLS) row_store entries and the tap stores, with no word taken.
module separable_convolution_zero_border #(
   parameter int MAX_TAPS = 71,
   parameter int MAX_COLS = 1024,
   parameter int MAX_ROWS = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // pixel[15:0], tap_index[22:16], coeff[40:23]
   input  wire logic [1:0]  req_tuser,   // mode[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [47:0] rsp_tdata,   // out_row[9:0], out_col[19:10], value[43:20]
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);
   import sce_pkg::*;

   localparam int N        = MAX_TAPS;
   localparam int TW       = $clog2(MAX_TAPS);
   localparam int CW       = $clog2(MAX_COLS);
   localparam int RW       = $clog2(MAX_ROWS);
   localparam int LW       = $clog2(MAX_COLS + 1);
   localparam int RLW      = $clog2(MAX_ROWS + 1);
   localparam int KW       = $clog2(MAX_TAPS + 2);
   localparam int TOP_RAW  = (MAX_TAPS - 1) | 1;
   localparam int TOP_W    = (TOP_RAW > MAX_TAPS) ? MAX_TAPS - 1 : TOP_RAW;
   localparam int RS_DEPTH = MAX_TAPS * (2 ** CW);
   localparam int RS_AW    = TW + CW;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_HMAC  = 3'd2;
   localparam logic [2:0] ST_HWR   = 3'd3;
   localparam logic [2:0] ST_VMAC  = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic [10:0] row_length_ff, row_count_ff;
   logic [6:0]  hwidth_ff, vwidth_ff;

   logic [RS_AW-1:0] clr_ff;
   logic [CW-1:0]    cur_col_ff;
   logic [RW-1:0]    cur_row_ff;
   logic [TW-1:0]    cur_slot_ff;

   logic [RW-1:0]    r_ff;
   logic [CW-1:0]    x_ff;
   logic [TW-1:0]    slot_ff, s_ff;
   logic [6:0]       hw_ff, vw_ff;
   logic [5:0]       rv_ff;
   logic             h_on_ff, v_on_ff;
   logic [KW-1:0]    k_ff;

   logic signed [TAP_W-1:0] htap_mem [MAX_TAPS];
   logic signed [TAP_W-1:0] vtap_mem [MAX_TAPS];
   logic signed [VAL_W-1:0] rs_mem   [RS_DEPTH];
   logic signed [TAP_W-1:0] htap_rd_ff, vtap_rd_ff;
   logic signed [VAL_W-1:0] rs_rd_ff;
   logic [PIX_W-1:0]        pix_a_ff;
   logic                    opv_ff, vph_ff;

   logic             rsp_valid_ff;
   logic [9:0]       rsp_row_ff, rsp_col_ff;
   logic [VAL_W-1:0] rsp_val_ff;

   logic [PIX_W-1:0] win_q [MAX_TAPS];

   logic [1:0]              in_mode;
   logic [PIX_W-1:0]        in_pixel;
   logic [6:0]              in_idx;
   logic signed [TAP_W-1:0] in_coeff;
   logic                    fire, pix_fire, load_ok;

   logic [LW-1:0]  len_c;
   logic [RLW-1:0] cnt_c;
   logic [6:0]     hw_c, vw_c, he, ve;
   logic [5:0]     rh_c, rv_c;
   logic [CW-1:0]  col_p;
   logic [RW:0]    row_a;
   logic [TW-1:0]  slot_a;
   logic [CW:0]    col_n;
   logic [RW:0]    row_n;
   logic [TW-1:0]  slot_n;

   mac_ctl_type             mac_ctl;
   logic signed [OPA_W-1:0] mac_a;
   logic signed [TAP_W-1:0] mac_b;
   logic signed [ACC_W-1:0] mac_acc;
   logic signed [VAL_W-1:0] h_val, v_val;
   logic [RW-1:0]           r_out;
   logic                    csr_wr;

   assign in_mode  = req_tuser;
   assign in_pixel = req_tdata[15:0];
   assign in_idx   = req_tdata[22:16];
   assign in_coeff = req_tdata[40:23];

   assign req_tready = (state_ff == ST_IDLE);
   assign fire       = req_tvalid && req_tready;
   assign pix_fire   = fire && (in_mode == MODE_PIXEL);
   assign load_ok    = {1'b0, in_idx} < 8'(MAX_TAPS);

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      case (csr_paddr[3:2])
         REG_ROW_LENGTH: csr_prdata = 32'(row_length_ff);
         REG_ROW_COUNT:  csr_prdata = 32'(row_count_ff);
         REG_HWIDTH:     csr_prdata = 32'(hwidth_ff);
         REG_VWIDTH:     csr_prdata = 32'(vwidth_ff);
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff <= 11'd1024;
         row_count_ff  <= 11'd1024;
         hwidth_ff     <= 7'd1;
         vwidth_ff     <= 7'd1;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_ROW_LENGTH: row_length_ff <= csr_pwdata[10:0];
            REG_ROW_COUNT:  row_count_ff  <= csr_pwdata[10:0];
            REG_HWIDTH:     hwidth_ff     <= csr_pwdata[6:0];
            REG_VWIDTH:     vwidth_ff     <= csr_pwdata[6:0];
            default:        row_length_ff <= row_length_ff;
         endcase
      end
   end

   always_comb begin
      if (row_length_ff == 11'd0) len_c = LW'(1);
      else if (row_length_ff > MAX_COLS) len_c = LW'(MAX_COLS);
      else len_c = LW'(row_length_ff);
      if (row_count_ff == 11'd0) cnt_c = RLW'(1);
      else if (row_count_ff > MAX_ROWS) cnt_c = RLW'(MAX_ROWS);
      else cnt_c = RLW'(row_count_ff);
      he   = hwidth_ff | 7'd1;
      ve   = vwidth_ff | 7'd1;
      hw_c = (he > TOP_W) ? 7'(TOP_W) : he;
      vw_c = (ve > TOP_W) ? 7'(TOP_W) : ve;
      rh_c = hw_c[6:1];
      rv_c = vw_c[6:1];

      col_p  = cur_col_ff;
      row_a  = {1'b0, cur_row_ff};
      slot_a = cur_slot_ff;
      if (cur_col_ff >= len_c) begin
         col_p  = '0;
         row_a  = row_a + 1'b1;
         slot_a = (slot_a == TW'(N - 1)) ? '0 : slot_a + 1'b1;
      end
      if (row_a >= cnt_c) begin
         row_a  = '0;
         slot_a = '0;
      end

      col_n  = {1'b0, col_p} + 1'b1;
      row_n  = row_a;
      slot_n = slot_a;
      if (col_n >= len_c) begin
         col_n  = '0;
         row_n  = row_a + 1'b1;
         slot_n = (slot_a == TW'(N - 1)) ? '0 : slot_a + 1'b1;
         if (row_n >= cnt_c) begin
            row_n  = '0;
            slot_n = '0;
         end
      end
   end

   for (genvar i = 0; i < MAX_TAPS; i++) begin : g_win
      sce_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (pix_fire),
         .rot_en   ((state_ff == ST_HMAC) && (k_ff < KW'(N))),
         .shift_in ((i == 0) ? in_pixel : win_q[(i == 0) ? 0 : i - 1]),
         .rot_in   ((i == N - 1) ? win_q[0] : win_q[(i == N - 1) ? 0 : i + 1]),
         .q        (win_q[i])
      );
   end

   assign h_val = h_on_ff ? round_sat(mac_acc) : '0;
   assign v_val = v_on_ff ? round_sat(mac_acc) : '0;
   assign r_out = r_ff - RW'(rv_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (clr_ff == RS_AW'(RS_DEPTH - 1)) state_in = ST_IDLE;
         ST_IDLE: begin
            if (pix_fire) begin
               if (col_p < rh_c) state_in = ST_IDLE;
               else if (col_p >= {rh_c, 1'b0}) state_in = ST_HMAC;
               else state_in = ST_HWR;
            end
         end
         ST_HMAC: if (k_ff == KW'(N + 1)) state_in = ST_HWR;
         ST_HWR: begin
            if (r_ff < rv_ff) state_in = ST_IDLE;
            else if (r_ff >= {rv_ff, 1'b0}) state_in = ST_VMAC;
            else state_in = ST_OUT;
         end
         ST_VMAC: if (k_ff == KW'({1'b0, vw_ff} + 8'd1)) state_in = ST_OUT;
         ST_OUT: if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         cur_slot_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (pix_fire) begin
            cur_col_ff  <= col_n[CW-1:0];
            cur_row_ff  <= row_n[RW-1:0];
            cur_slot_ff <= slot_n;
         end
         if (state_ff == ST_OUT && (!rsp_valid_ff || rsp_tready)) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_fire) begin
         r_ff    <= row_a[RW-1:0];
         x_ff    <= col_p - CW'(rh_c);
         slot_ff <= slot_a;
         hw_ff   <= hw_c;
         vw_ff   <= vw_c;
         rv_ff   <= rv_c;
         h_on_ff <= col_p >= {rh_c, 1'b0};
         k_ff    <= '0;
      end else if (state_ff == ST_HWR) begin
         v_on_ff <= r_ff >= {rv_ff, 1'b0};
         s_ff    <= slot_ff;
         k_ff    <= '0;
      end else if (state_ff == ST_HMAC) begin
         k_ff <= k_ff + 1'b1;
      end else if (state_ff == ST_VMAC) begin
         k_ff <= k_ff + 1'b1;
         s_ff <= (s_ff == '0) ? TW'(N - 1) : s_ff - 1'b1;
      end
      if (state_ff == ST_OUT && (!rsp_valid_ff || rsp_tready)) begin
         rsp_row_ff <= 10'(r_out);
         rsp_col_ff <= 10'(x_ff);
         rsp_val_ff <= v_val;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR && clr_ff < RS_AW'(N)) begin
         htap_mem[clr_ff[TW-1:0]] <= '0;
         vtap_mem[clr_ff[TW-1:0]] <= '0;
      end else if (fire && load_ok && in_mode == MODE_HTAP) begin
         htap_mem[in_idx[TW-1:0]] <= in_coeff;
      end else if (fire && load_ok && in_mode == MODE_VTAP) begin
         vtap_mem[in_idx[TW-1:0]] <= in_coeff;
      end
      htap_rd_ff <= htap_mem[k_ff[TW-1:0]];
      vtap_rd_ff <= vtap_mem[k_ff[TW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) rs_mem[clr_ff] <= '0;
      else if (state_ff == ST_HWR) rs_mem[{slot_ff, x_ff}] <= h_val;
      rs_rd_ff <= rs_mem[{s_ff, x_ff}];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         opv_ff <= 1'b0;
         vph_ff <= 1'b0;
      end else begin
         opv_ff <= ((state_ff == ST_HMAC) && (k_ff < KW'(hw_ff))) ||
                   ((state_ff == ST_VMAC) && (k_ff < KW'(vw_ff)));
         vph_ff <= (state_ff == ST_VMAC);
      end
      pix_a_ff <= win_q[0];
   end

   assign mac_ctl.clear = pix_fire || (state_ff == ST_HWR);
   assign mac_ctl.valid = opv_ff;
   assign mac_a = vph_ff ? OPA_W'(rs_rd_ff) : OPA_W'({1'b0, pix_a_ff});
   assign mac_b = vph_ff ? vtap_rd_ff : htap_rd_ff;

   sce_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (mac_ctl),
      .a     (mac_a),
      .b     (mac_b),
      .acc   (mac_acc)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_val_ff, rsp_col_ff, rsp_row_ff};

endmodule
`default_nettype wire

// ===== tb/sv/separable_convolution_zero_border_tb.sv =====
`timescale 1ns / 1ps
module separable_convolution_zero_border_tb;
   import sce_pkg::*;

   localparam int NTAPS = 71;
   localparam int NCOLS = 1024;
   localparam int NROWS = 1024;
   localparam logic [1:0] MODE_NONE = 2'd3;
   localparam int SETTLE = 200;

   typedef struct {
      logic [9:0]  row;
      logic [9:0]  col;
      logic [23:0] value;
   } pix_out_type;

   class conv_scoreboard;
      int unsigned row_len, row_cnt, hwid, vwid;
      int htap[NTAPS];
      int vtap[NTAPS];
      int unsigned window[NTAPS];
      int line_buf[NTAPS*NCOLS];
      int unsigned cur_row, cur_col;
      pix_out_type pending[$];
      int errors;

      function void clear();
         row_len = 1024; row_cnt = 1024; hwid = 1; vwid = 1;
         foreach (htap[i]) begin htap[i] = 0; vtap[i] = 0; window[i] = 0; end
         foreach (line_buf[i]) line_buf[i] = 0;
         cur_row = 0; cur_col = 0; errors = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [31:0] val);
         case (idx)
            REG_ROW_LENGTH: row_len = val[10:0];
            REG_ROW_COUNT: row_cnt = val[10:0];
            REG_HWIDTH: hwid = val[6:0];
            REG_VWIDTH: vwid = val[6:0];
            default: row_len = row_len;
         endcase
      endfunction

      function int unsigned fit_width(int unsigned w);
         int unsigned e;
         e = w | 1;
         return (e > NTAPS) ? NTAPS : e;
      endfunction

      function int unsigned fit_size(int unsigned v, int unsigned maxv);
         if (v == 0) return 1;
         return (v > maxv) ? maxv : v;
      endfunction

      function int round_q(longint acc);
         bit neg;
         longint mag;
         neg = acc < 0;
         mag = neg ? -acc : acc;
         mag = (mag + 32768) >> 16;
         if (neg) return (mag > 8388608) ? -8388608 : -int'(mag);
         return (mag > 8388607) ? 8388607 : int'(mag);
      endfunction

      function void step_pos(int unsigned len, int unsigned cnt);
         cur_col++;
         if (cur_col >= len) begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= cnt) cur_row = 0;
         end
      endfunction

      function void note_word(logic [1:0] mode, logic [15:0] pix, logic [6:0] idx,
                              logic signed [17:0] co);
         int unsigned len, cnt, hw, vw, rh, rv, r, c, x, slot, s;
         int h, v;
         longint acc;
         pix_out_type o;
         h = 0; v = 0;
         if (mode == MODE_HTAP || mode == MODE_VTAP) begin
            if (idx < NTAPS) begin
               if (mode == MODE_HTAP) htap[idx] = co;
               else vtap[idx] = co;
            end
            return;
         end
         if (mode != MODE_PIXEL) return;
         len = fit_size(row_len, NCOLS);
         cnt = fit_size(row_cnt, NROWS);
         hw = fit_width(hwid);
         vw = fit_width(vwid);
         rh = hw >> 1;
         rv = vw >> 1;
         if (cur_col >= len) begin
            cur_col = 0;
            cur_row++;
         end
         if (cur_row >= cnt) cur_row = 0;
         r = cur_row;
         c = cur_col;
         for (int j = NTAPS - 1; j > 0; j--) window[j] = window[j-1];
         window[0] = pix;
         if (c < rh) begin
            step_pos(len, cnt);
            return;
         end
         x = c - rh;
         if (c >= 2 * rh) begin
            acc = 0;
            for (int j = 0; j < hw; j++) acc += longint'(window[j]) * longint'(htap[j]);
            h = round_q(acc);
         end
         slot = r % NTAPS;
         line_buf[slot*NCOLS + x] = h;
         if (r < rv) begin
            step_pos(len, cnt);
            return;
         end
         if (r >= 2 * rv) begin
            acc = 0;
            for (int j = 0; j < vw; j++) begin
               s = (slot + NTAPS - j) % NTAPS;
               acc += longint'(line_buf[s*NCOLS + x]) * longint'(vtap[j]);
            end
            v = round_q(acc);
         end
         o.row = 10'(r - rv);
         o.col = 10'(x);
         o.value = 24'(v);
         pending.push_back(o);
         step_pos(len, cnt);
      endfunction

      function void check_word(logic [47:0] data);
         pix_out_type e;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected word: row %0d col %0d value %h",
                                       data[9:0], data[19:10], data[43:20]);
            return;
         end
         e = pending.pop_front();
         if (data[9:0] !== e.row || data[19:10] !== e.col || data[43:20] !== e.value) begin
            errors++;
            if (errors <= 10)
               $display({"mismatch: expected row %0d col %0d value %h, ",
                         "got row %0d col %0d value %h"},
                        e.row, e.col, e.value, data[9:0], data[19:10], data[43:20]);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   conv_scoreboard sb;
   int tx_idle;
   int rx_idle;

   separable_convolution_zero_border i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #30_000_000;
      $display("separable_convolution_zero_border_tb: errors");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_word(rsp_tdata);
      rsp_tready <= ($urandom_range(99) >= rx_idle);
   end

   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      sb.set_reg(idx, val);
   endtask

   task automatic send_word(logic [1:0] mode, logic [15:0] pix, logic [6:0] idx,
                            logic signed [17:0] co);
      if ($urandom_range(99) < tx_idle) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= {7'd0, co, idx, pix};
      do @(posedge clock); while (!req_tready);
      sb.note_word(mode, pix, idx, co);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic configure(logic [31:0] len, logic [31:0] cnt, logic [31:0] hw,
                            logic [31:0] vw);
      write_reg(REG_ROW_LENGTH, len);
      write_reg(REG_ROW_COUNT, cnt);
      write_reg(REG_HWIDTH, hw);
      write_reg(REG_VWIDTH, vw);
   endtask

   task automatic load_kernels(int hw, int vw);
      for (int j = 0; j < hw && j < NTAPS; j++)
         send_word(MODE_HTAP, 16'd0, 7'(j), 18'($urandom_range(0, 262143)));
      for (int j = 0; j < vw && j < NTAPS; j++)
         send_word(MODE_VTAP, 16'd0, 7'(j), 18'($urandom_range(0, 262143)));
   endtask

   task automatic random_words(int n);
      int k;
      logic [15:0] p;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(99);
         p = 16'($urandom);
         if ($urandom_range(9) == 0) p = ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
         if (k < 6)
            send_word(MODE_HTAP, p, 7'($urandom), 18'($urandom));
         else if (k < 12)
            send_word(MODE_VTAP, p, 7'($urandom), 18'($urandom));
         else if (k < 14)
            send_word(MODE_NONE, p, 7'($urandom), 18'($urandom));
         else
            send_word(MODE_PIXEL, p, 7'($urandom), 18'($urandom));
      end
   endtask

   initial begin
      sb = new();
      sb.clear();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      tx_idle = 35;
      rx_idle = 63;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (!req_tready) @(posedge clock);

      send_word(MODE_HTAP, 16'd0, 7'd0, 18'sh1FFFF);
      send_word(MODE_VTAP, 16'd0, 7'd0, 18'sh1FFFF);
      send_word(MODE_PIXEL, 16'hFFFF, 7'd0, 18'sd0);
      send_word(MODE_PIXEL, 16'h0000, 7'd0, 18'sd0);
      send_word(MODE_HTAP, 16'd0, 7'd0, -18'sd131072);
      send_word(MODE_PIXEL, 16'hFFFF, 7'd0, 18'sd0);
      send_word(MODE_VTAP, 16'd0, 7'd0, -18'sd131072);
      send_word(MODE_PIXEL, 16'hFFFF, 7'd0, 18'sd0);
      send_word(MODE_PIXEL, 16'h0001, 7'd0, 18'sd0);
      send_word(MODE_HTAP, 16'hFFFF, 7'd127, 18'sh1FFFF);
      send_word(MODE_VTAP, 16'hFFFF, 7'd71, 18'sh1FFFF);
      send_word(MODE_HTAP, 16'd0, 7'd70, 18'sd5);
      send_word(MODE_NONE, 16'hFFFF, 7'd127, 18'sh3FFFF);
      send_word(MODE_PIXEL, 16'h8000, 7'd127, 18'sh3FFFF);
      send_word(MODE_HTAP, 16'd0, 7'd0, 18'sd65536);
      send_word(MODE_VTAP, 16'd0, 7'd0, 18'sd65536);
      send_word(MODE_PIXEL, 16'h1234, 7'd0, 18'sd0);
      drain();

      configure(8, 6, 3, 3);
      load_kernels(3, 3);
      random_words(240);
      drain();

      configure(1, 1, 2, 5);
      random_words(30);
      drain();

      tx_idle = 63;
      rx_idle = 35;
      configure(80, 40, 71, 7);
      load_kernels(71, 7);
      random_words(260);
      drain();

      configure(5, 9, 4, 0);
      load_kernels(5, 1);
      random_words(230);
      drain();

      tx_idle = 0;
      rx_idle = 0;
      configure(2047, 0, 1, 9);
      random_words(30);
      drain();

      configure(6, 80, 127, 71);
      write_reg(REG_HWIDTH, 1);
      load_kernels(1, 71);
      random_words(330);
      drain();

      if (sb.errors == 0) begin
         $display("separable_convolution_zero_border_tb: clean");
      end else begin
         $display("separable_convolution_zero_border_tb: errors");
      end
      $finish;
   end

endmodule
